>>> rtl/core/dvft_pkg.sv
// Shared types and constants of the distinct value frequency table.
package dvft_pkg;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 32;
    localparam int SLOT_W  = 6;

    localparam logic [COUNT_W-1:0] COUNT_START = COUNT_W'(1);
    localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;

    // Item modes.
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_READ   = 1'b1;

    // Request travelling along the cell chain, together with what it has found so far.
    typedef struct packed {
        logic                      active;
        logic                      mode;
        logic signed [VALUE_W-1:0] value;
        logic [SLOT_W-1:0]         index;
        logic                      hit;
        logic                      is_new;
        logic [SLOT_W-1:0]         slot;
        logic [COUNT_W-1:0]        count;
    } t_pkt;

endpackage

>>> rtl/core/dvft_in_if.sv
// Input channel: one insert or read request per transaction.
interface dvft_in_if import dvft_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      mode;
    logic signed [VALUE_W-1:0] value;
    logic [SLOT_W-1:0]         index;

    modport source (output valid, output mode, output value, output index, input ready);
    modport sink   (input valid, input mode, input value, input index, output ready);
endinterface

>>> rtl/core/dvft_out_if.sv
// Output channel: one result per transaction.
interface dvft_out_if import dvft_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [SLOT_W-1:0]         slot;
    logic signed [VALUE_W-1:0] entry_value;
    logic [COUNT_W-1:0]        count;
    logic                      is_new;
    logic                      entry_valid;
    logic                      dropped;

    modport source (output valid, output slot, output entry_value, output count,
                    output is_new, output entry_valid, output dropped, input ready);
    modport sink   (input valid, input slot, input entry_value, input count,
                    input is_new, input entry_valid, input dropped, output ready);
endinterface

>>> rtl/core/dvft_cell.sv
// One table slot: holds a value and its count and serves the request passing through.
module dvft_cell import dvft_pkg::*; #(
    parameter int CELL_NUM = 0,
    parameter int USED_W   = 7
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [USED_W-1:0] i_used,
    input  t_pkt              i_pkt,
    output t_pkt              o_pkt
);

    localparam logic [USED_W-1:0] MY_NUM  = USED_W'(CELL_NUM);
    localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(CELL_NUM);
    localparam logic [31:0]       MY_NUM32 = 32'(CELL_NUM);

    t_pkt                      r_pkt;
    t_pkt                      n_pkt;
    logic signed [VALUE_W-1:0] r_value;
    logic signed [VALUE_W-1:0] n_value;
    logic [COUNT_W-1:0]        r_count;
    logic [COUNT_W-1:0]        n_count;
    logic                      w_occupied;
    logic                      w_index_hit;

    assign w_occupied  = (MY_NUM < i_used);
    assign w_index_hit = (MY_NUM32 == {{(32-SLOT_W){1'b0}}, i_pkt.index});

    // Match, count, read or append, for the first cell that can resolve the request.
    always_comb begin
        n_pkt   = i_pkt;
        n_value = r_value;
        n_count = r_count;
        if (i_pkt.active && !i_pkt.hit) begin
            if (w_occupied) begin
                if (i_pkt.mode == MODE_INSERT && r_value == i_pkt.value) begin
                    if (r_count != COUNT_MAX) begin
                        n_count = r_count + COUNT_W'(1);
                    end
                    n_pkt.hit   = 1'b1;
                    n_pkt.slot  = MY_SLOT;
                    n_pkt.count = n_count;
                end else if (i_pkt.mode == MODE_READ && w_index_hit) begin
                    n_pkt.hit   = 1'b1;
                    n_pkt.slot  = MY_SLOT;
                    n_pkt.value = r_value;
                    n_pkt.count = r_count;
                end
            end else if (MY_NUM == i_used && i_pkt.mode == MODE_INSERT) begin
                n_value      = i_pkt.value;
                n_count      = COUNT_START;
                n_pkt.hit    = 1'b1;
                n_pkt.is_new = 1'b1;
                n_pkt.slot   = MY_SLOT;
                n_pkt.count  = COUNT_START;
            end
        end
    end

    // Request stage toward the next cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pkt.active <= 1'b0;
        end else begin
            r_pkt <= n_pkt;
        end
    end

    // Slot contents.
    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_count <= n_count;
    end

    assign o_pkt = r_pkt;

endmodule

>>> rtl/core/distinct_value_frequency_table.sv
// Distinct value frequency table: a chain of slot cells with an output stage.
//
// Usage: each input transaction on i_in is either an insert (mode 0), which
// counts value, or a read (mode 1), which returns the slot at index. Every
// input transaction yields exactly one output transaction on o_out.
// An insert that finds its value raises that slot's count, saturating at
// all ones; a new value is appended with count 1; when all TABLE_DEPTH slots
// are taken, a new value is discarded and flagged by dropped.
// The request walks the row of TABLE_DEPTH cells, one cell per cycle, each
// cell registering it, and one request is in the table at a time. A
// finished result sits in a holding register and then in the output
// register, which drives o_out.valid; the input stays closed until the
// result has moved into the output register, so a stalled receiver holds
// off the next request.
// Reset empties the table (the fill count goes to zero), drops any request
// or result in flight and keeps i_in.ready low while it is asserted.
module distinct_value_frequency_table import dvft_pkg::*; #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dvft_in_if.sink    i_in,
    dvft_out_if.source o_out
);

    localparam int USED_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [USED_W-1:0] FULL_COUNT = USED_W'(TABLE_DEPTH);

    t_pkt                      w_pkt [TABLE_DEPTH+1];
    t_pkt                      w_head;
    logic [USED_W-1:0]         r_used;
    logic                      r_busy;
    logic                      r_pend_full;
    t_pkt                      r_pend;
    logic                      r_out_valid;
    logic [SLOT_W-1:0]         r_out_slot;
    logic signed [VALUE_W-1:0] r_out_value;
    logic [COUNT_W-1:0]        r_out_count;
    logic                      r_out_is_new;
    logic                      r_out_valid_entry;
    logic                      r_out_dropped;
    logic                      w_accept;
    logic                      w_load_out;
    t_pkt                      w_last;

    assign i_in.ready = i_rst_n && !r_busy;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_last     = w_pkt[TABLE_DEPTH];
    assign w_load_out = r_pend_full && (!r_out_valid || o_out.ready);

    // Request entering the first cell.
    always_comb begin
        w_head        = '0;
        w_head.active = w_accept;
        w_head.mode   = i_in.mode;
        w_head.value  = i_in.value;
        w_head.index  = i_in.index;
    end

    assign w_pkt[0] = w_head;

    // Row of slot cells.
    for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
        dvft_cell #(
            .CELL_NUM (k),
            .USED_W   (USED_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_used  (r_used),
            .i_pkt   (w_pkt[k]),
            .o_pkt   (w_pkt[k+1])
        );
    end

    // Fill count, busy flag and holding register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= '0;
            r_busy      <= 1'b0;
            r_pend_full <= 1'b0;
        end else begin
            if (w_last.active && w_last.is_new && r_used != FULL_COUNT) begin
                r_used <= r_used + USED_W'(1);
            end
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_load_out) begin
                r_busy <= 1'b0;
            end
            if (w_last.active) begin
                r_pend_full <= 1'b1;
            end else if (w_load_out) begin
                r_pend_full <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_last.active) begin
            r_pend <= w_last;
        end
    end

    // Output register: shape the result from the finished request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_is_new      <= r_pend.is_new;
            r_out_valid_entry <= r_pend.hit;
            r_out_dropped     <= (r_pend.mode == MODE_INSERT) && !r_pend.hit;
            if (r_pend.hit) begin
                r_out_slot  <= r_pend.slot;
                r_out_value <= r_pend.value;
                r_out_count <= r_pend.count;
            end else if (r_pend.mode == MODE_READ) begin
                r_out_slot  <= r_pend.index;
                r_out_value <= '0;
                r_out_count <= '0;
            end else begin
                r_out_slot  <= '0;
                r_out_value <= r_pend.value;
                r_out_count <= '0;
            end
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.slot        = r_out_slot;
    assign o_out.entry_value = r_out_value;
    assign o_out.count       = r_out_count;
    assign o_out.is_new      = r_out_is_new;
    assign o_out.entry_valid = r_out_valid_entry;
    assign o_out.dropped     = r_out_dropped;

endmodule
